// ===== rtl/core/spq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes of the sorted priority queue: operation and status
// codes, controller states, and the command and status groups that join the
// controller to the datapath.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  typedef enum logic [1:0] {
    STAT_DEQ_OK = 2'd0,
    STAT_EMPTY  = 2'd1,
    STAT_ENQ_OK = 2'd2,
    STAT_FULL   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_CMP,
    ST_INS,
    ST_DEQ,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic latch;
    logic start_walk;
    logic shift;
    logic write_new;
    logic head_read;
    logic finish_deq;
    logic set_empty;
    logic set_full;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic op_deq;
    logic full;
    logic empty;
    logic greater;
    logic last;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== rtl/core/spq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_ctrl
// Sequencer of the queue: takes one transaction, walks the datapath through
// the insertion or removal, and hands the result to the output register.
// ----------------------------------------------------------------------------
module spq_ctrl
  import spq_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  dp_stat_t stat_i,
  output cmd_t     cmd_o,
  output logic     in_stall_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        if (!stat_i.op_deq) begin
          if (stat_i.full) state_d = ST_EMIT;
          else if (stat_i.empty) state_d = ST_INS;
          else state_d = ST_CMP;
        end else begin
          if (stat_i.empty) state_d = ST_EMIT;
          else state_d = ST_DEQ;
        end
      end
      ST_CMP: begin
        if (stat_i.greater) begin
          if (stat_i.last) state_d = ST_INS;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_INS:  state_d = ST_EMIT;
      ST_DEQ:  state_d = ST_EMIT;
      ST_EMIT: begin
        if (stat_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o  = 1'b0;
        cmd_o.latch = in_valid_i;
      end
      ST_DISPATCH: begin
        if (!stat_i.op_deq) begin
          if (stat_i.full) cmd_o.set_full = 1'b1;
          else cmd_o.start_walk = 1'b1;
        end else begin
          if (stat_i.empty) cmd_o.set_empty = 1'b1;
          else cmd_o.head_read = 1'b1;
        end
      end
      ST_CMP: begin
        if (stat_i.greater) cmd_o.shift = 1'b1;
        else cmd_o.write_new = 1'b1;
      end
      ST_INS:  cmd_o.write_new  = 1'b1;
      ST_DEQ:  cmd_o.finish_deq = 1'b1;
      ST_EMIT: cmd_o.emit       = stat_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

// ===== rtl/core/spq_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_datapath
// Entry store as a ring buffer in memory, with head, tail and fill count,
// the insertion walk pointers, the result register and the output register.
// ----------------------------------------------------------------------------
module spq_datapath
  import spq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cmd_t       cmd_i,
  output dp_stat_t   stat_o,
  input  logic       operation_i,
  input  logic [7:0] data_byte_i,
  input  logic [7:0] priority_req_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] status_o,
  output logic [7:0] out_byte_o,
  output logic [7:0] out_priority_o,
  output logic [4:0] fill_count_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    return (p == '0) ? AW'(DEPTH - 1) : p - AW'(1);
  endfunction

  logic [7:0] mem_byte [DEPTH];
  logic [7:0] mem_prio [DEPTH];

  logic          op_q;
  logic [7:0]    byte_q, prio_q;
  logic [AW-1:0] head_q, head_d, tail_q, tail_d;
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] rd_ptr_q, rd_ptr_d, wr_ptr_q, wr_ptr_d;
  logic [CW-1:0] left_q, left_d;
  logic [7:0]    rd_byte_q, rd_prio_q;
  status_e       res_status_q;
  logic [7:0]    res_byte_q, res_prio_q;
  logic          out_valid_q;
  logic [1:0]    out_status_q;
  logic [7:0]    out_byte_q, out_prio_q;
  logic [4:0]    out_fill_q;

  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    wr_byte, wr_prio;

  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    count_d  = count_q;
    rd_ptr_d = rd_ptr_q;
    wr_ptr_d = wr_ptr_q;
    left_d   = left_q;
    rd_en    = 1'b0;
    rd_addr  = head_q;
    wr_en    = 1'b0;
    wr_byte  = byte_q;
    wr_prio  = prio_q;
    if (cmd_i.start_walk) begin
      rd_en    = 1'b1;
      rd_addr  = ptr_dec(tail_q);
      rd_ptr_d = ptr_dec(tail_q);
      wr_ptr_d = tail_q;
      left_d   = count_q;
    end
    if (cmd_i.shift) begin
      wr_en    = 1'b1;
      wr_byte  = rd_byte_q;
      wr_prio  = rd_prio_q;
      wr_ptr_d = rd_ptr_q;
      left_d   = left_q - CW'(1);
      if (left_q != CW'(1)) begin
        rd_en    = 1'b1;
        rd_addr  = ptr_dec(rd_ptr_q);
        rd_ptr_d = ptr_dec(rd_ptr_q);
      end
    end
    if (cmd_i.write_new) begin
      wr_en   = 1'b1;
      count_d = count_q + CW'(1);
      tail_d  = ptr_inc(tail_q);
    end
    if (cmd_i.head_read) begin
      rd_en   = 1'b1;
      rd_addr = head_q;
    end
    if (cmd_i.finish_deq) begin
      count_d = count_q - CW'(1);
      head_d  = ptr_inc(head_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_byte[wr_ptr_q] <= wr_byte;
      mem_prio[wr_ptr_q] <= wr_prio;
    end
    if (rd_en) begin
      rd_byte_q <= mem_byte[rd_addr];
      rd_prio_q <= mem_prio[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      if (cmd_i.emit) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_ptr_q <= rd_ptr_d;
    wr_ptr_q <= wr_ptr_d;
    left_q   <= left_d;
    if (cmd_i.latch) begin
      op_q   <= operation_i;
      byte_q <= data_byte_i;
      prio_q <= priority_req_i;
    end
    if (cmd_i.write_new) begin
      res_status_q <= STAT_ENQ_OK;
      res_byte_q   <= '0;
      res_prio_q   <= '0;
    end else if (cmd_i.set_full) begin
      res_status_q <= STAT_FULL;
      res_byte_q   <= '0;
      res_prio_q   <= '0;
    end else if (cmd_i.set_empty) begin
      res_status_q <= STAT_EMPTY;
      res_byte_q   <= '0;
      res_prio_q   <= '0;
    end else if (cmd_i.finish_deq) begin
      res_status_q <= STAT_DEQ_OK;
      res_byte_q   <= rd_byte_q;
      res_prio_q   <= rd_prio_q;
    end
    if (cmd_i.emit) begin
      out_status_q <= res_status_q;
      out_byte_q   <= res_byte_q;
      out_prio_q   <= res_prio_q;
      out_fill_q   <= 5'(count_q);
    end
  end

  assign stat_o.op_deq   = (op_q == OP_DEQ);
  assign stat_o.full     = (count_q == CW'(DEPTH));
  assign stat_o.empty    = (count_q == '0);
  assign stat_o.greater  = (rd_prio_q > prio_q);
  assign stat_o.last     = (left_q == CW'(1));
  assign stat_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign out_byte_o     = out_byte_q;
  assign out_priority_o = out_prio_q;
  assign fill_count_o   = out_fill_q;

endmodule

// ===== rtl/core/sorted_priority_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue of DEPTH entries (data byte and priority) kept in
// ascending priority order; equal priorities leave first-in first-out.
// ----------------------------------------------------------------------------
// One transaction is in flight at a time and gives exactly one result. The
// entries sit in a ring buffer memory with one read and one write port, so
// a dequeue reads the head, while an enqueue walks back from the tail,
// moving one entry up per cycle past every held entry with a priority
// above the new one. An enqueue into a full queue or a dequeue from an
// empty one goes straight to its result. A finished result waits in the
// output register while the next transaction is accepted. No clearing
// pass runs after reset.
module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       operation_i,
  input  logic [7:0] data_byte_i,
  input  logic [7:0] priority_req_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] status_o,
  output logic [7:0] out_byte_o,
  output logic [7:0] out_priority_o,
  output logic [4:0] fill_count_o
);

  cmd_t     cmd;
  dp_stat_t stat;

  spq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  spq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .operation_i    (operation_i),
    .data_byte_i    (data_byte_i),
    .priority_req_i (priority_req_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .out_byte_o     (out_byte_o),
    .out_priority_o (out_priority_o),
    .fill_count_o   (fill_count_o)
  );

endmodule

// ===== rtl/core/spq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_assert
// Port-level checks of the sorted priority queue, bound to the top level.
// ----------------------------------------------------------------------------
module spq_assert
  import spq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       operation_i,
  input logic [7:0] data_byte_i,
  input logic [7:0] priority_req_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] status_o,
  input logic [7:0] out_byte_o,
  input logic [7:0] out_priority_o,
  input logic [4:0] fill_count_o
);

  logic in_take;
  logic in_payload_seen;

  assign in_take         = in_valid_i && !in_stall_o;
  assign in_payload_seen = operation_i || (data_byte_i != '0) || (priority_req_i != '0);

  a_busy_after_accept: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_take |=> in_stall_o
  ) else $error("queue accepted a transaction while one was in flight");

  a_no_data_unless_removed: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != STAT_DEQ_OK) |-> (out_byte_o == '0) && (out_priority_o == '0)
  ) else $error("result carries data without a removal");

  a_full_count: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STAT_FULL) |-> (fill_count_o == 5'(DEPTH))
  ) else $error("full result with a count other than the depth");

  a_empty_count: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STAT_EMPTY) |-> (fill_count_o == '0) || !in_payload_seen
      && (fill_count_o == '0)
  ) else $error("empty result with a nonzero count");

  a_out_hold: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) && $stable(out_byte_o)
      && $stable(out_priority_o) && $stable(fill_count_o)
  ) else $error("stalled result changed");

endmodule

bind sorted_priority_queue spq_assert #(.DEPTH(DEPTH)) u_spq_checker (.*);

// ===== tb/sv/spq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_checker
// Watches both channels of the sorted priority queue. Keeps its own sorted
// copy of the held entries, works out the status, removed entry and fill
// count of every accepted transaction, and compares each accepted result
// field by field with the oldest outstanding one.
// ----------------------------------------------------------------------------
module spq_checker
  import spq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic       operation_i,
  input  logic [7:0] data_byte_i,
  input  logic [7:0] priority_req_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [1:0] status_i,
  input  logic [7:0] out_byte_i,
  input  logic [7:0] out_priority_i,
  input  logic [4:0] fill_count_i,
  output int         fail_count_o,
  output int         pending_o
);

  typedef struct packed {
    status_e    status;
    logic [7:0] payload;
    logic [7:0] rank;
    logic [4:0] fill;
  } spq_result_t;

  logic [7:0]  held_payload [DEPTH];
  logic [7:0]  held_rank [DEPTH];
  int          held_count;
  spq_result_t awaited_q [$];

  function automatic spq_result_t serve_request(input logic op, input logic [7:0] payload,
                                                input logic [7:0] rank);
    spq_result_t res;
    int          slot;
    res = '{status: STAT_ENQ_OK, payload: 8'h00, rank: 8'h00, fill: 5'd0};
    if (op == OP_ENQ) begin
      if (held_count >= DEPTH) begin
        res.status = STAT_FULL;
      end else begin
        slot = 0;
        while (slot < held_count && held_rank[slot] <= rank) slot++;
        for (int i = held_count; i > slot; i--) begin
          held_payload[i] = held_payload[i-1];
          held_rank[i]    = held_rank[i-1];
        end
        held_payload[slot] = payload;
        held_rank[slot]    = rank;
        held_count++;
      end
    end else if (held_count == 0) begin
      res.status = STAT_EMPTY;
    end else begin
      res.status  = STAT_DEQ_OK;
      res.payload = held_payload[0];
      res.rank    = held_rank[0];
      for (int i = 1; i < held_count; i++) begin
        held_payload[i-1] = held_payload[i];
        held_rank[i-1]    = held_rank[i];
      end
      held_count--;
    end
    res.fill = 5'(held_count);
    return res;
  endfunction

  task automatic compare_field(input string field, input int want, input int got);
    if (want != got) begin
      fail_count_o++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    spq_result_t want;
    if (!rst_ni) begin
      held_count = 0;
      awaited_q.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (awaited_q.size() == 0) begin
          fail_count_o++;
          $display("%0t: unexpected result, expected none, actual status=%0d byte=%0d prio=%0d fill=%0d",
                   $time, status_i, out_byte_i, out_priority_i, fill_count_i);
        end else begin
          want = awaited_q.pop_front();
          compare_field("status", want.status, status_i);
          compare_field("out_byte", want.payload, out_byte_i);
          compare_field("out_priority", want.rank, out_priority_i);
          compare_field("fill_count", want.fill, fill_count_i);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        awaited_q.push_back(serve_request(operation_i, data_byte_i, priority_req_i));
      end
      pending_o = awaited_q.size();
    end
  end

endmodule

// ===== tb/sv/sorted_priority_queue_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_test
// Drives the sorted priority queue with a directed opening (empty dequeue,
// extreme and tied priorities, fill to full, dropped enqueues) and then
// random enqueue/dequeue mixes that swing between full and empty, under
// random sender and receiver gaps, one long receiver hold and one drain.
// ----------------------------------------------------------------------------
module sorted_priority_queue_test;
  import spq_pkg::*;

  localparam int DEPTH         = 16;
  localparam int RANDOM_ITEMS  = 1150;
  localparam int BLOCK_ITEMS   = 50;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int LONG_HOLD     = 400;
  localparam int HOLD_AT_COUNT = 300;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic       operation_i;
  logic [7:0] data_byte_i;
  logic [7:0] priority_req_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [1:0] status_o;
  logic [7:0] out_byte_o;
  logic [7:0] out_priority_o;
  logic [4:0] fill_count_o;

  int fail_count;
  int pending_count;
  int cycle_count = 0;
  bit tx_quiet = 1'b0;

  sorted_priority_queue #(.DEPTH(DEPTH)) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .data_byte_i    (data_byte_i),
    .priority_req_i (priority_req_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .out_byte_o     (out_byte_o),
    .out_priority_o (out_priority_o),
    .fill_count_o   (fill_count_o)
  );

  spq_checker #(.DEPTH(DEPTH)) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .operation_i    (operation_i),
    .data_byte_i    (data_byte_i),
    .priority_req_i (priority_req_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_i       (status_o),
    .out_byte_i     (out_byte_o),
    .out_priority_i (out_priority_o),
    .fill_count_i   (fill_count_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending_count)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_request(input logic op, input logic [7:0] payload,
                              input logic [7:0] rank);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    operation_i    <= op;
    data_byte_i    <= payload;
    priority_req_i <= rank;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain_queue();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending_count != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // result side: per-transaction gaps, quiet stretches, one long hold
  initial begin : result_sink
    int  stall_left;
    int  taken;
    bit  quiet;
    stall_left  = 0;
    taken       = 0;
    quiet       = 1'b0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        taken++;
        if (taken % 64 == 0) quiet = ($urandom_range(0, 2) == 0);
        if (taken == HOLD_AT_COUNT) stall_left = LONG_HOLD;
        else stall_left = quiet ? 0 : $urandom_range(0, 7);
        out_stall_i <= (stall_left > 0);
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= (stall_left > 0);
      end
    end
  end

  initial begin : request_source
    int enq_pct;
    int rank_span;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    operation_i    = OP_ENQ;
    data_byte_i    = 8'h00;
    priority_req_i = 8'h00;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(OP_DEQ, 8'hFF, 8'hFF);
    send_request(OP_ENQ, 8'h00, 8'hFF);
    send_request(OP_ENQ, 8'hFF, 8'h00);
    send_request(OP_ENQ, 8'h01, 8'h80);
    send_request(OP_ENQ, 8'h02, 8'h80);
    send_request(OP_ENQ, 8'h03, 8'h80);
    send_request(OP_ENQ, 8'h80, 8'h00);
    send_request(OP_ENQ, 8'h7F, 8'hFF);
    send_request(OP_ENQ, 8'h55, 8'h01);
    send_request(OP_ENQ, 8'hAA, 8'hFE);
    for (int i = 0; i < 7; i++) begin
      send_request(OP_ENQ, 8'(8'h10 + i), (i % 2 == 0) ? 8'h80 : 8'h7F);
    end
    send_request(OP_ENQ, 8'h5A, 8'h00);
    send_request(OP_ENQ, 8'hA5, 8'hFF);
    repeat (4) send_request(OP_DEQ, 8'($urandom), 8'($urandom));

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % BLOCK_ITEMS == 0) begin
        case ($urandom_range(0, 3))
          0: enq_pct = 25;
          1: enq_pct = 50;
          2: enq_pct = 75;
          default: enq_pct = 90;
        endcase
        case ($urandom_range(0, 2))
          0: rank_span = 3;
          1: rank_span = 15;
          default: rank_span = 255;
        endcase
        tx_quiet = ($urandom_range(0, 3) == 0);
      end
      if (n == RANDOM_ITEMS / 2) drain_queue();
      if ($urandom_range(0, 99) < enq_pct) begin
        send_request(OP_ENQ, 8'($urandom), 8'($urandom_range(0, rank_span)));
      end else begin
        send_request(OP_DEQ, 8'($urandom), 8'($urandom));
      end
    end

    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending_count != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/spq_pkg.sv
rtl/core/spq_ctrl.sv
rtl/core/spq_datapath.sv
rtl/core/sorted_priority_queue.sv
rtl/core/spq_checker.sv
tb/sv/spq_checker.sv
tb/sv/sorted_priority_queue_test.sv
